// ===== rtl/pcd_pkg.sv =====
// ---------------------------------------------------------------------------
// pcd_pkg
// Shared types, codes and widths of the prefix-code table decoder.
// ---------------------------------------------------------------------------
package pcd_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned DEF_TABLE_ENTRIES = 256;
  localparam int unsigned DEF_MAX_CODE_LEN  = 32;

  // Fixed field widths
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned ENT_LEN_W = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SKIP_W    = 3;
  localparam int unsigned ENTRY_W   = SYM_W + CODE_W + ENT_LEN_W;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_SKIP_BITS = 1'b0;  // register index (paddr[2])

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_DATA  = 2'd2
  } pcd_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_FULL     = 2'd2
  } pcd_status_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_all;
    logic load_entry;
    logic set_full;
    logic start_byte;
    logic skip_bit;
    logic shift_bit;
    logic scan_start;
    logic scan_next;
    logic set_hit;
    logic set_ovf;
    logic emit;
    logic flush;
    logic next_bit;
  } pcd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_nz;
    logic bit_last;
    logic tbl_empty;
    logic tbl_full;
    logic hit;
    logic scan_last;
    logic len_full;
    logic pend_valid;
    logic out_free;
  } pcd_stat_t;

endpackage

// ===== rtl/pcd_ram.sv =====
// ---------------------------------------------------------------------------
// pcd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pcd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcd_ctrl.sv =====
// ---------------------------------------------------------------------------
// pcd_ctrl
// Sequencer: walks each data byte bit by bit and scans the code table.
// ---------------------------------------------------------------------------
module pcd_ctrl import pcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  action_i,
  output logic        in_stall_o,
  output pcd_cmd_t    cmd_o,
  input  pcd_stat_t   stat_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BIT   = 6'b000010,
    S_CMP   = 6'b000100,
    S_MISS  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (pcd_action_e'(action_i))
            ACT_CLEAR: cmd_o.clear_all = 1'b1;
            ACT_LOAD: begin
              if (stat_i.tbl_full) begin
                cmd_o.set_full = 1'b1;
                state_d        = S_FLUSH;
              end else begin
                cmd_o.load_entry = 1'b1;
              end
            end
            ACT_DATA: begin
              cmd_o.start_byte = 1'b1;
              state_d          = S_BIT;
            end
            default: ;
          endcase
        end
      end
      S_BIT: begin
        if (stat_i.skip_nz) begin
          cmd_o.skip_bit = 1'b1;
          if (stat_i.bit_last) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.next_bit = 1'b1;
          end
        end else begin
          cmd_o.shift_bit = 1'b1;
          if (stat_i.tbl_empty) begin
            state_d = S_MISS;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (stat_i.hit) begin
          cmd_o.set_hit = 1'b1;
          state_d       = S_EMIT;
        end else if (!stat_i.scan_last) begin
          cmd_o.scan_next = 1'b1;
        end else begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        if (stat_i.len_full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_EMIT;
        end else if (stat_i.bit_last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.next_bit = 1'b1;
          state_d        = S_BIT;
        end
      end
      S_EMIT: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.bit_last) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.next_bit = 1'b1;
            state_d        = S_BIT;
          end
        end
      end
      S_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/pcd_dp.sv =====
// ---------------------------------------------------------------------------
// pcd_dp
// Datapath: code table, bit accumulator, pending result and output word.
// ---------------------------------------------------------------------------
module pcd_dp import pcd_pkg::*; #(
  parameter int unsigned TableEntries = DEF_TABLE_ENTRIES,
  parameter int unsigned MaxCodeLen   = DEF_MAX_CODE_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcd_cmd_t             cmd_i,
  output pcd_stat_t            stat_o,
  input  logic [SKIP_W-1:0]    skip_bits_i,
  input  logic [SYM_W-1:0]     entry_symbol_i,
  input  logic [CODE_W-1:0]    entry_code_i,
  input  logic [ENT_LEN_W-1:0] entry_length_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [SYM_W-1:0]     symbol_o,
  output logic [1:0]           status_o,
  output logic                 last_o
);

  localparam int unsigned AddrW   = $clog2(TableEntries);
  localparam int unsigned CntW    = $clog2(TableEntries + 1);
  localparam int unsigned AccW    = MaxCodeLen;
  localparam int unsigned AccLenW = $clog2(MaxCodeLen + 1);
  localparam int unsigned CmpW    = (AccW > CODE_W) ? AccW : CODE_W;
  localparam int unsigned LenCmpW = (AccLenW > ENT_LEN_W) ? AccLenW : ENT_LEN_W;
  localparam int unsigned BitIdxW = $clog2(BYTE_W);

  logic [CntW-1:0]    count_q, count_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [AccLenW-1:0] acc_len_q, acc_len_d;
  logic [SKIP_W-1:0]  skip_left_q, skip_left_d;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [SYM_W-1:0]   res_sym_q, res_sym_d;
  pcd_status_e        res_status_q, res_status_d;
  logic               pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]   pend_sym_q, pend_sym_d;
  pcd_status_e        pend_status_q, pend_status_d;
  logic               out_valid_q, out_valid_d;
  logic [SYM_W-1:0]   out_sym_q, out_sym_d;
  pcd_status_e        out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic [CODE_W-1:0]  code_mask;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;
  logic [SYM_W-1:0]   rd_sym;
  logic [CODE_W-1:0]  rd_code;
  logic [ENT_LEN_W-1:0] rd_len;
  logic               cur_bit;
  logic               out_load;

  // Keep only the code bits below the entry length
  always_comb begin
    for (int k = 0; k < CODE_W; k++) begin
      code_mask[k] = (ENT_LEN_W'(k) < entry_length_i);
    end
  end

  assign wr_entry = {entry_symbol_i, entry_code_i & code_mask, entry_length_i};

  pcd_ram #(
    .Width (ENTRY_W),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_entry),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_d),
    .rdata_o (rd_entry)
  );

  assign rd_sym  = rd_entry[ENTRY_W-1 -: SYM_W];
  assign rd_code = rd_entry[ENT_LEN_W +: CODE_W];
  assign rd_len  = rd_entry[ENT_LEN_W-1:0];
  assign cur_bit = byte_q[bit_idx_q];

  assign stat_o.skip_nz    = (skip_left_q != '0);
  assign stat_o.bit_last   = (bit_idx_q == '0);
  assign stat_o.tbl_empty  = (count_q == '0);
  assign stat_o.tbl_full   = (count_q >= CntW'(TableEntries));
  assign stat_o.hit        = (LenCmpW'(rd_len) == LenCmpW'(acc_len_q)) &&
                             (CmpW'(rd_code) == CmpW'(acc_q));
  assign stat_o.scan_last  = ((CntW'(idx_q) + CntW'(1)) >= count_q);
  assign stat_o.len_full   = (acc_len_q >= AccLenW'(MaxCodeLen));
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    count_d       = count_q;
    acc_d         = acc_q;
    acc_len_d     = acc_len_q;
    skip_left_d   = skip_left_q;
    byte_d        = byte_q;
    bit_idx_d     = bit_idx_q;
    idx_d         = idx_q;
    res_sym_d     = res_sym_q;
    res_status_d  = res_status_q;
    pend_valid_d  = pend_valid_q;
    pend_sym_d    = pend_sym_q;
    pend_status_d = pend_status_q;

    if (cmd_i.clear_all) begin
      count_d     = '0;
      acc_d       = '0;
      acc_len_d   = '0;
      skip_left_d = skip_bits_i;
    end
    if (cmd_i.load_entry) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.start_byte) begin
      byte_d    = data_byte_i;
      bit_idx_d = BitIdxW'(BYTE_W - 1);
    end
    if (cmd_i.skip_bit) begin
      skip_left_d = skip_left_q - SKIP_W'(1);
    end
    if (cmd_i.next_bit) begin
      bit_idx_d = bit_idx_q - BitIdxW'(1);
    end
    if (cmd_i.shift_bit) begin
      acc_d     = {acc_q[AccW-2:0], cur_bit};
      acc_len_d = acc_len_q + AccLenW'(1);
    end
    if (cmd_i.scan_start) begin
      idx_d = '0;
    end
    if (cmd_i.scan_next) begin
      idx_d = idx_q + AddrW'(1);
    end
    if (cmd_i.set_hit) begin
      res_sym_d    = rd_sym;
      res_status_d = ST_OK;
      acc_d        = '0;
      acc_len_d    = '0;
    end
    if (cmd_i.set_ovf) begin
      res_sym_d    = '0;
      res_status_d = ST_OVERFLOW;
      acc_d        = '0;
      acc_len_d    = '0;
    end
    if (cmd_i.set_full) begin
      pend_valid_d  = 1'b1;
      pend_sym_d    = '0;
      pend_status_d = ST_FULL;
    end
    if (cmd_i.emit) begin
      pend_valid_d  = 1'b1;
      pend_sym_d    = res_sym_q;
      pend_status_d = res_status_q;
    end
    if (cmd_i.flush) begin
      pend_valid_d = 1'b0;
    end
  end

  // Push the held result to the output word; it is last only on flush
  assign out_load = (cmd_i.emit && pend_valid_q) || cmd_i.flush;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_sym_d    = pend_sym_q;
      out_status_d = pend_status_q;
      out_last_d   = cmd_i.flush;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      acc_q        <= '0;
      acc_len_q    <= '0;
      skip_left_q  <= '0;
      bit_idx_q    <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      acc_q        <= acc_d;
      acc_len_q    <= acc_len_d;
      skip_left_q  <= skip_left_d;
      bit_idx_q    <= bit_idx_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q        <= byte_d;
    res_sym_q     <= res_sym_d;
    res_status_q  <= res_status_d;
    pend_sym_q    <= pend_sym_d;
    pend_status_q <= pend_status_d;
    out_sym_q     <= out_sym_d;
    out_status_q  <= out_status_d;
    out_last_q    <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = out_sym_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

// ===== rtl/prefix_code_table_decoder_core.sv =====
// ---------------------------------------------------------------------------
// prefix_code_table_decoder_core
// Prefix-code decoder with a loadable code table and an APB skip register.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o  | action, entry fields, data byte
//   out     | output    | out_valid_o/out_stall_i| symbol, status, last
//   cfg     | input     | psel/penable/pwrite    | skip_bits at address 0
//
// Clear, load and unused words complete in the idle state; a load into a full
// table posts a table-full result and flushes it. A data byte starts, skips
// bits while the skip count is nonzero, and for each decoded bit shifts it in,
// scans the table entries and resolves, posts an overflow when the code reaches
// the maximum length, then closes the byte. The table read port scans one entry
// per cycle.
// Reset empties the table, the accumulator and both result registers.
// A stalled output holds its word; the decoder waits only when a second
// result needs the output register while it is still occupied.
// ---------------------------------------------------------------------------
module prefix_code_table_decoder_core import pcd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned MAX_CODE_LEN  = DEF_MAX_CODE_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [SYM_W-1:0]     entry_symbol_i,
  input  logic [CODE_W-1:0]    entry_code_i,
  input  logic [ENT_LEN_W-1:0] entry_length_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SYM_W-1:0]     symbol_o,
  output logic [1:0]           status_o,
  output logic                 last_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  pcd_cmd_t          cmd;
  pcd_stat_t         stat;
  logic [SKIP_W-1:0] skip_bits_q, skip_bits_d;
  logic              cfg_wr;

  // Skip register: applies at the next clear, never to the running stream
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SKIP_BITS);
  assign skip_bits_d = cfg_wr ? pwdata[SKIP_W-1:0] : skip_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_bits_q <= '0;
    end else begin
      skip_bits_q <= skip_bits_d;
    end
  end

  assign prdata = (paddr[2] == REG_SKIP_BITS) ? APB_DW'(skip_bits_q) : '0;

  pcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  pcd_dp #(
    .TableEntries (TABLE_ENTRIES),
    .MaxCodeLen   (MAX_CODE_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .skip_bits_i    (skip_bits_q),
    .entry_symbol_i (entry_symbol_i),
    .entry_code_i   (entry_code_i),
    .entry_length_i (entry_length_i),
    .data_byte_i    (data_byte_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .symbol_o       (symbol_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/pcd_checker.sv =====
// ---------------------------------------------------------------------------
// pcd_checker
// Port-level checks of the prefix-code decoder, bound to the top level.
// ---------------------------------------------------------------------------
module pcd_checker import pcd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [1:0]       action_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SYM_W-1:0] symbol_o,
  input logic [1:0]       status_o,
  input logic             last_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o) &&
                                   $stable(status_o) && $stable(last_o))
    else $error("stalled result word changed");

  // Error results carry no symbol
  a_err_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> symbol_o == '0)
    else $error("error result with non-zero symbol");

  // Table full is the only result of its load
  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> last_o)
    else $error("table-full result not marked last");

  // Clear leaves the decoder free in the next cycle
  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_CLEAR) |=> !in_stall_o)
    else $error("decoder busy after clear");

endmodule

bind prefix_code_table_decoder_core pcd_checker u_pcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_o    (symbol_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
